FILE: rtl/lcdt_pkg.sv
// ----------------------------------------------------------------------------
// LCD timing package
// Shared types and codes for the LCD mode sequencer and its checker.
// ----------------------------------------------------------------------------
package lcdt_pkg;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcdt_mode_t;

	typedef enum logic [1:0] {
		CMD_ADVANCE = 2'd0,
		CMD_LCDC    = 2'd1,
		CMD_STAT    = 2'd2,
		CMD_LY      = 2'd3
	} lcdt_cmd_t;

	// bit positions inside the STAT source enables
	localparam int unsigned EN_HBLANK = 0;
	localparam int unsigned EN_VBLANK = 1;
	localparam int unsigned EN_OAM    = 2;
	localparam int unsigned EN_LYC    = 3;

	// result word bit positions
	localparam int unsigned RES_STAT_IRQ   = 16;
	localparam int unsigned RES_VBLANK_IRQ = 17;
	localparam int unsigned RES_FRAME_RDY  = 18;
	localparam int unsigned RES_RENDER     = 19;
	localparam int unsigned RES_VRAM_OPEN  = 20;
	localparam int unsigned RES_OAM_OPEN   = 21;

	localparam logic [7:0] LINE_VBLANK = 8'd144;
	localparam logic [7:0] LINE_LAST   = 8'd153;

	typedef struct packed {
		lcdt_mode_t  mode;
		logic [9:0]  cc;
		logic [7:0]  line;
		logic [3:0]  ed;
		logic [1:0]  skip;
		logic        vss;
		logic        fired;
		logic        off;
		logic [3:0]  en;
		logic        drawn;
	} lcdt_state_t;

endpackage

FILE: rtl/lcd_mode_timing_stat_interrupts.sv
// ----------------------------------------------------------------------------
// LCD mode timing and STAT interrupts
// Scanline mode sequencer with LY, STAT byte, interrupt and access flags.
// ----------------------------------------------------------------------------
// One item is accepted every clock while the result side keeps up; each item
// yields exactly one result word, which passes through the input register and
// then the result register. The rate is set by the single combinational update
// of the timing state between those two registers. s_tuser carries the command
// (advance, LCDC write, STAT write, LY write).
module lcd_mode_timing_stat_interrupts (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] cycles, [14:7] data, [22:15] compare_line, [30:23] scx, [31] zero
	input  logic [31:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] line, [15:8] stat_value, [16] stat_irq, [17] vblank_irq,
	// [18] frame_ready, [19] render_line, [20] vram_open, [21] oam_open, [23:22] zero
	output logic [23:0] m_tdata
);

	logic                 valid_s1;
	lcdt_pkg::lcdt_cmd_t  cmd_s1;
	logic [6:0]           cycles_s1;
	logic [7:0]           data_s1;
	logic [7:0]           lyc_s1;
	logic [7:0]           scx_s1;

	logic                 valid_s2;
	logic [23:0]          res_s2;

	lcdt_pkg::lcdt_state_t st_q;
	lcdt_pkg::lcdt_state_t st_nxt;

	logic       advance;
	logic       p_stat, p_vbl, p_ready, p_render;
	logic [7:0] stat_byte;
	logic [23:0] res_nxt;

	function automatic lcdt_pkg::lcdt_state_t src_oam(input lcdt_pkg::lcdt_state_t s);
		lcdt_pkg::lcdt_state_t r;
		r = s;
		if (r.en[lcdt_pkg::EN_OAM] && r.skip == 2'd0 && !r.fired)
			r.fired = 1'b1;
		if (r.skip != 2'd0)
			r.skip = r.skip - 2'd1;
		r.vss = 1'b0;
		return r;
	endfunction

	function automatic lcdt_pkg::lcdt_state_t src_hblank(input lcdt_pkg::lcdt_state_t s);
		lcdt_pkg::lcdt_state_t r;
		r = s;
		if (r.en[lcdt_pkg::EN_HBLANK] && !r.fired) begin
			r.fired = 1'b1;
			r.skip  = 2'd1;
		end
		return r;
	endfunction

	function automatic lcdt_pkg::lcdt_state_t src_vblank(input lcdt_pkg::lcdt_state_t s);
		lcdt_pkg::lcdt_state_t r;
		r = s;
		if (r.en[lcdt_pkg::EN_VBLANK]) begin
			if (!r.fired) begin
				r.fired = 1'b1;
				r.vss   = 1'b1;
			end
		end else if (r.line == lcdt_pkg::LINE_VBLANK) begin
			r = src_oam(r);
		end
		return r;
	endfunction

	function automatic lcdt_pkg::lcdt_state_t src_lyc(input lcdt_pkg::lcdt_state_t s,
			input logic [7:0] lyc);
		lcdt_pkg::lcdt_state_t r;
		r = s;
		if (r.en[lcdt_pkg::EN_LYC] && r.line == lyc && !r.vss && !r.fired) begin
			r.fired = 1'b1;
			if (r.line < lcdt_pkg::LINE_VBLANK)
				r.skip = 2'd1;
		end
		return r;
	endfunction

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1    <= lcdt_pkg::lcdt_cmd_t'(s_tuser);
			cycles_s1 <= s_tdata[6:0];
			data_s1   <= s_tdata[14:7];
			lyc_s1    <= s_tdata[22:15];
			scx_s1    <= s_tdata[30:23];
		end
	end

	// state update for the item in the input register
	always_comb begin
		logic [10:0] sum;
		logic [10:0] old;
		logic [10:0] vlen;
		logic [10:0] thr;
		logic [2:0]  fine;

		st_nxt   = st_q;
		p_vbl    = 1'b0;
		p_ready  = 1'b0;
		p_render = 1'b0;
		old  = {1'b0, st_q.cc};
		sum  = old + {4'd0, cycles_s1};
		vlen = 11'd172 + {7'd0, st_q.ed};
		thr  = 11'd200 - {7'd0, st_q.ed};
		fine = scx_s1[2:0];

		case (cmd_s1)
			lcdt_pkg::CMD_ADVANCE: begin
				st_nxt.fired = 1'b0;
				if (!st_q.off) begin
					st_nxt.cc = sum[9:0];
					case (st_q.mode)
						lcdt_pkg::MODE_OAM: begin
							if (sum >= 11'd84) begin
								st_nxt.cc   = 10'(sum - 11'd84);
								st_nxt.ed   = (fine > 3'd4) ? 4'd8 :
									((fine != 3'd0) ? 4'd4 : 4'd0);
								st_nxt.mode = lcdt_pkg::MODE_XFER;
							end
						end
						lcdt_pkg::MODE_XFER: begin
							if (sum >= vlen && !st_q.drawn) begin
								p_render     = (st_q.line < lcdt_pkg::LINE_VBLANK);
								st_nxt.drawn = 1'b1;
							end
							if (old < vlen - 11'd4 && sum >= vlen - 11'd4)
								st_nxt = src_hblank(st_nxt);
							if (sum >= vlen) begin
								st_nxt.cc   = 10'(sum - vlen);
								st_nxt.mode = lcdt_pkg::MODE_HBLANK;
							end
						end
						lcdt_pkg::MODE_HBLANK: begin
							if (sum >= thr) begin
								st_nxt.cc    = 10'(sum - thr);
								st_nxt.drawn = 1'b0;
								st_nxt.line  = st_q.line + 8'd1;
								st_nxt = src_lyc(st_nxt, lyc_s1);
								if (st_nxt.line >= lcdt_pkg::LINE_VBLANK) begin
									p_vbl       = 1'b1;
									p_ready     = 1'b1;
									st_nxt.mode = lcdt_pkg::MODE_VBLANK;
									st_nxt = src_vblank(st_nxt);
								end else begin
									st_nxt.mode = lcdt_pkg::MODE_OAM;
									st_nxt = src_oam(st_nxt);
								end
							end
						end
						default: begin
							// line 153 folds to LY 0 early, mode stays VBLANK
							if (st_q.line >= lcdt_pkg::LINE_LAST && sum >= 11'd56) begin
								st_nxt.line = 8'd0;
								st_nxt = src_lyc(st_nxt, lyc_s1);
								if (st_nxt.skip == 2'd1)
									st_nxt.skip = 2'd2;
							end else if (sum >= 11'd456) begin
								st_nxt.cc   = 10'(sum - 11'd456);
								st_nxt.line = st_q.line + 8'd1;
								if (st_nxt.line == 8'd1) begin
									st_nxt.line = 8'd0;
									st_nxt.mode = lcdt_pkg::MODE_OAM;
									st_nxt = src_oam(st_nxt);
								end
								if (st_nxt.line != 8'd0)
									st_nxt = src_lyc(st_nxt, lyc_s1);
							end
						end
					endcase
				end
			end
			lcdt_pkg::CMD_LCDC: begin
				if (data_s1[7]) begin
					if (st_q.off) begin
						st_nxt.mode = lcdt_pkg::MODE_HBLANK;
						st_nxt.cc   = 10'd116;
						st_nxt = src_lyc(st_nxt, lyc_s1);
					end
					st_nxt.off = 1'b0;
				end else if (!st_q.off) begin
					p_ready     = 1'b1;
					st_nxt.off  = 1'b1;
					st_nxt.line = 8'd0;
					st_nxt.mode = lcdt_pkg::MODE_HBLANK;
				end
			end
			lcdt_pkg::CMD_STAT: begin
				st_nxt.en = data_s1[6:3];
			end
			default: begin
				st_nxt.line = 8'd0;
			end
		endcase

		// the flag is cleared by every advance, so a set flag after one means it fired
		p_stat = st_nxt.fired && (cmd_s1 == lcdt_pkg::CMD_ADVANCE || !st_q.fired);
	end

	always_comb begin
		stat_byte = {1'b1, st_nxt.en, (st_nxt.line == lyc_s1), st_nxt.mode};
		res_nxt   = {2'b00,
			st_nxt.off || (st_nxt.mode != lcdt_pkg::MODE_XFER &&
				st_nxt.mode != lcdt_pkg::MODE_OAM),
			st_nxt.off || (st_nxt.mode != lcdt_pkg::MODE_XFER),
			p_render, p_ready, p_vbl, p_stat,
			stat_byte, st_nxt.line};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '{mode: lcdt_pkg::MODE_OAM, default: '0};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res_nxt;
	end

endmodule

FILE: rtl/lcdt_checker.sv
// ----------------------------------------------------------------------------
// LCD timing port checker
// Watches the result stream of the LCD mode sequencer for illegal words.
// ----------------------------------------------------------------------------
module lcdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// LY never runs past the last VBLANK line
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] <= lcdt_pkg::LINE_LAST)
		else $error("LY out of range");

	// rendering only happens on visible lines
	a_render: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[lcdt_pkg::RES_RENDER] |->
			m_tdata[7:0] < lcdt_pkg::LINE_VBLANK)
		else $error("render pulse on a VBLANK line");

	// VBLANK entry completes a frame; closed VRAM means closed OAM
	a_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[lcdt_pkg::RES_VBLANK_IRQ] ||
			m_tdata[lcdt_pkg::RES_FRAME_RDY]) &&
			(m_tdata[lcdt_pkg::RES_VRAM_OPEN] || !m_tdata[lcdt_pkg::RES_OAM_OPEN]) &&
			m_tdata[15])
		else $error("inconsistent interrupt or access flags");

endmodule

bind lcd_mode_timing_stat_interrupts lcdt_checker u_lcdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/lcd_mode_timing_stat_interrupts_test.sv
// ----------------------------------------------------------------------------
// LCD mode timing and STAT interrupt testbench
// Streams advance and register-write words into the sequencer and checks
// every result word against a cycle-count model of the scanline modes,
// interrupt sources and access flags. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module lcd_mode_timing_stat_interrupts_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned OAM_CYCLES  = 84;
	localparam int unsigned XFER_CYCLES = 172;
	localparam int unsigned HBLANK_END  = 200;
	localparam int unsigned LINE_CYCLES = 456;
	localparam int unsigned SHORT_LINE  = 56;
	localparam int unsigned LINE_LATENCY = 20;

	// how the driver fills compare_line when it presents a word
	typedef enum logic [1:0] {
		LYC_FREE,
		LYC_SAME,
		LYC_NEXT
	} lyc_pick_t;

	typedef struct {
		lcdt_pkg::lcdt_cmd_t cmd;
		logic [6:0]  cycles;
		logic [7:0]  data;
		logic [7:0]  lyc;
		logic [7:0]  scx;
		lyc_pick_t   pick;
		int          gap;
	} lcd_word_t;

	typedef struct {
		logic [7:0] line;
		logic [7:0] stat;
		logic       stat_irq;
		logic       vblank_irq;
		logic       frame_ready;
		logic       render_line;
		logic       vram_open;
		logic       oam_open;
	} lcd_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [6:0] cycles, [14:7] data, [22:15] compare_line, [30:23] scx, [31] zero
	logic [31:0] s_tdata = '0;
	// [1:0] command
	logic [1:0]  s_tuser = lcdt_pkg::CMD_ADVANCE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] line, [15:8] stat_value, [16] stat_irq, [17] vblank_irq,
	// [18] frame_ready, [19] render_line, [20] vram_open, [21] oam_open
	logic [23:0] m_tdata;

	lcd_mode_timing_stat_interrupts dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lcd_word_t   pending_words[$];
	lcd_result_t expected_results[$];
	lcd_word_t   live_word;

	int mismatches = 0;
	int words_sent = 0;
	int words_seen = 0;
	int stat_irqs = 0;
	int vblank_irqs = 0;
	int frames = 0;
	int rendered = 0;
	int send_burst = 0;
	int recv_burst = 0;

	// timing model state
	lcdt_pkg::lcdt_mode_t tm_mode;
	int unsigned tm_cc;
	logic [7:0]  tm_line;
	int unsigned tm_delay;
	int unsigned tm_skip;
	bit          tm_vblank_seen;
	bit          tm_fired;
	bit          tm_off;
	logic [3:0]  tm_en;
	bit          tm_drawn;

	// per-word events
	logic [7:0]  ev_lyc;
	bit          ev_stat, ev_vbl, ev_ready, ev_render;

	function automatic void timing_reset();
		tm_mode = lcdt_pkg::MODE_OAM;
		tm_cc = 0;
		tm_line = '0;
		tm_delay = 0;
		tm_skip = 0;
		tm_vblank_seen = 0;
		tm_fired = 0;
		tm_off = 0;
		tm_en = '0;
		tm_drawn = 0;
	endfunction

	function automatic bit stat_request();
		if (tm_fired)
			return 0;
		tm_fired = 1;
		ev_stat = 1;
		return 1;
	endfunction

	function automatic void oam_source();
		if (tm_en[lcdt_pkg::EN_OAM] && tm_skip == 0)
			void'(stat_request());
		if (tm_skip != 0)
			tm_skip--;
		tm_vblank_seen = 0;
	endfunction

	function automatic void hblank_source();
		if (tm_en[lcdt_pkg::EN_HBLANK] && stat_request())
			tm_skip = 1;
	endfunction

	function automatic void vblank_source();
		if (tm_en[lcdt_pkg::EN_VBLANK]) begin
			if (stat_request())
				tm_vblank_seen = 1;
		end else if (tm_line == lcdt_pkg::LINE_VBLANK) begin
			oam_source();
		end
	endfunction

	function automatic void lyc_source();
		if (tm_en[lcdt_pkg::EN_LYC] && tm_line == ev_lyc && !tm_vblank_seen) begin
			if (stat_request() && tm_line < lcdt_pkg::LINE_VBLANK)
				tm_skip = 1;
		end
	endfunction

	function automatic void advance_time(logic [6:0] cycles, logic [7:0] scx);
		int unsigned xfer_len;
		int unsigned prior;
		int unsigned hblank_len;
		tm_fired = 0;
		if (tm_off)
			return;
		xfer_len = XFER_CYCLES + tm_delay;
		prior = tm_cc;
		tm_cc += cycles;
		case (tm_mode)
			lcdt_pkg::MODE_OAM: begin
				if (tm_cc >= OAM_CYCLES) begin
					tm_cc -= OAM_CYCLES;
					tm_delay = (scx[2:0] > 3'd4) ? 8 : ((scx[2:0] > 3'd0) ? 4 : 0);
					tm_mode = lcdt_pkg::MODE_XFER;
				end
			end
			lcdt_pkg::MODE_XFER: begin
				if (tm_cc >= xfer_len && !tm_drawn) begin
					if (tm_line < lcdt_pkg::LINE_VBLANK)
						ev_render = 1;
					tm_drawn = 1;
				end
				// HBLANK source fires when tm_cc crosses xfer_len - 4, ahead of the mode change
				if (prior < xfer_len - 4 && tm_cc >= xfer_len - 4)
					hblank_source();
				if (tm_cc >= xfer_len) begin
					tm_cc -= xfer_len;
					tm_mode = lcdt_pkg::MODE_HBLANK;
				end
			end
			lcdt_pkg::MODE_HBLANK: begin
				hblank_len = HBLANK_END - tm_delay;
				if (tm_cc >= hblank_len) begin
					tm_cc -= hblank_len;
					tm_drawn = 0;
					tm_line = tm_line + 8'd1;
					lyc_source();
					if (tm_line >= lcdt_pkg::LINE_VBLANK) begin
						ev_vbl = 1;
						ev_ready = 1;
						tm_mode = lcdt_pkg::MODE_VBLANK;
						vblank_source();
					end else begin
						tm_mode = lcdt_pkg::MODE_OAM;
						oam_source();
					end
				end
			end
			default: begin
				// last line reads as LY 0 after its short stretch
				if (tm_line >= lcdt_pkg::LINE_LAST && tm_cc >= SHORT_LINE) begin
					tm_line = '0;
					lyc_source();
					if (tm_skip == 1)
						tm_skip = 2;
				end else if (tm_cc >= LINE_CYCLES) begin
					tm_cc -= LINE_CYCLES;
					tm_line = tm_line + 8'd1;
					if (tm_line == 8'd1) begin
						tm_line = '0;
						tm_mode = lcdt_pkg::MODE_OAM;
						oam_source();
					end
					if (tm_line != 8'd0)
						lyc_source();
				end
			end
		endcase
	endfunction

	function automatic void lcdc_write(logic [7:0] data);
		if (data[7]) begin
			if (tm_off) begin
				tm_mode = lcdt_pkg::MODE_HBLANK;
				tm_cc = HBLANK_END - OAM_CYCLES;
				lyc_source();
			end
			tm_off = 0;
		end else if (!tm_off) begin
			ev_ready = 1;
			tm_off = 1;
			tm_line = '0;
			tm_mode = lcdt_pkg::MODE_HBLANK;
		end
	endfunction

	function automatic lcd_result_t timing_step(lcd_word_t w);
		lcd_result_t r;
		ev_lyc = w.lyc;
		ev_stat = 0;
		ev_vbl = 0;
		ev_ready = 0;
		ev_render = 0;
		case (w.cmd)
			lcdt_pkg::CMD_ADVANCE: advance_time(w.cycles, w.scx);
			lcdt_pkg::CMD_LCDC:    lcdc_write(w.data);
			lcdt_pkg::CMD_STAT:    tm_en = w.data[6:3];
			default:               tm_line = '0;
		endcase
		r.line = tm_line;
		r.stat = {1'b1, tm_en, tm_line == ev_lyc, tm_mode};
		r.stat_irq = ev_stat;
		r.vblank_irq = ev_vbl;
		r.frame_ready = ev_ready;
		r.render_line = ev_render;
		r.vram_open = tm_off || tm_mode != lcdt_pkg::MODE_XFER;
		r.oam_open = tm_off || (tm_mode != lcdt_pkg::MODE_XFER &&
			tm_mode != lcdt_pkg::MODE_OAM);
		return r;
	endfunction

	function automatic int pause_len(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			burst_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic add_word(lcdt_pkg::lcdt_cmd_t cmd, logic [6:0] cycles, logic [7:0] data,
			logic [7:0] lyc, logic [7:0] scx);
		lcd_word_t w;
		w.cmd = cmd;
		w.cycles = cycles;
		w.data = data;
		w.lyc = lyc;
		w.scx = scx;
		w.pick = LYC_FREE;
		w.gap = pause_len(send_burst);
		pending_words.push_back(w);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	// driver: model each accepted word, then present the next one after its gap
	int idle_count = 0;
	always @(posedge clk or negedge arst_n) begin
		lcd_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= lcdt_pkg::CMD_ADVANCE;
			idle_count = 0;
			timing_reset();
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(timing_step(live_word));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() > 0 && idle_count >= pending_words[0].gap) begin
					w = pending_words.pop_front();
					if (w.pick == LYC_SAME)
						w.lyc = tm_line;
					else if (w.pick == LYC_NEXT)
						w.lyc = tm_line + 8'd1;
					live_word = w;
					idle_count = 0;
					s_tvalid <= 1'b1;
					s_tuser <= w.cmd;
					s_tdata <= {1'b0, w.scx, w.lyc, w.data, w.cycles};
				end else begin
					if (pending_words.size() > 0)
						idle_count++;
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result word, then hold off for a drawn stall
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		lcd_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (expected_results.size() == 0) begin
					$error("result word 0x%06h arrived with nothing expected", m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("line", want.line, m_tdata[7:0]);
					check_field("stat_value", want.stat, m_tdata[15:8]);
					check_field("stat_irq", want.stat_irq,
						m_tdata[lcdt_pkg::RES_STAT_IRQ]);
					check_field("vblank_irq", want.vblank_irq,
						m_tdata[lcdt_pkg::RES_VBLANK_IRQ]);
					check_field("frame_ready", want.frame_ready,
						m_tdata[lcdt_pkg::RES_FRAME_RDY]);
					check_field("render_line", want.render_line,
						m_tdata[lcdt_pkg::RES_RENDER]);
					check_field("vram_open", want.vram_open,
						m_tdata[lcdt_pkg::RES_VRAM_OPEN]);
					check_field("oam_open", want.oam_open,
						m_tdata[lcdt_pkg::RES_OAM_OPEN]);
					stat_irqs += want.stat_irq;
					vblank_irqs += want.vblank_irq;
					frames += want.frame_ready;
					rendered += want.render_line;
				end
				stall_left = pause_len(recv_burst);
			end
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		#5ms;
		$display("FAIL lcd_mode_timing_stat_interrupts");
		$finish;
	end

	initial begin
		lcd_word_t w;
		int roll;
		int total_words;

		// directed: field extremes, every command, off/on corners
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd0, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_STAT, 7'd0, 8'hFF, 8'hFF, 8'hFF);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd127, 8'h00, 8'h00, 8'h07);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd127, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd64, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd127, 8'h00, 8'h01, 8'h00);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd127, 8'h00, 8'h01, 8'h00);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd100, 8'h00, 8'h01, 8'h04);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd100, 8'h00, 8'h01, 8'h05);
		add_word(lcdt_pkg::CMD_LCDC, 7'd0, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_LCDC, 7'd0, 8'h7F, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd127, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_LY, 7'd0, 8'hAA, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_LCDC, 7'd0, 8'h80, 8'h00, 8'h00);
		// second enable without an advance between: the request stays dropped
		add_word(lcdt_pkg::CMD_LCDC, 7'd0, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_LCDC, 7'd0, 8'hFF, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_LCDC, 7'd0, 8'hFF, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_STAT, 7'd0, 8'h00, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd0, 8'h00, 8'h00, 8'h01);
		add_word(lcdt_pkg::CMD_ADVANCE, 7'd127, 8'hFF, 8'hFF, 8'hFF);
		add_word(lcdt_pkg::CMD_STAT, 7'd127, 8'h08, 8'h00, 8'h00);
		add_word(lcdt_pkg::CMD_LY, 7'd0, 8'h55, 8'h00, 8'h00);

		// random: a long run of mostly large advances that walks a full frame,
		// through VBLANK and the short last line, then a noisy mix of commands
		for (int i = 0; i < 950; i++) begin
			roll = $urandom_range(0, 99);
			w.cycles = $urandom_range(0, 127);
			w.data = $urandom_range(0, 255);
			w.lyc = $urandom_range(0, 255);
			w.scx = $urandom_range(0, 255);
			w.gap = pause_len(send_burst);
			if (i < 800) begin
				if (roll < 96) begin
					w.cmd = lcdt_pkg::CMD_ADVANCE;
					if ($urandom_range(0, 4) != 0)
						w.cycles = $urandom_range(90, 127);
				end else begin
					w.cmd = lcdt_pkg::CMD_STAT;
				end
				roll = $urandom_range(0, 9);
				w.pick = (roll < 6) ? LYC_NEXT : ((roll < 8) ? LYC_SAME : LYC_FREE);
			end else begin
				if (roll < 70)
					w.cmd = lcdt_pkg::CMD_ADVANCE;
				else if (roll < 82)
					w.cmd = lcdt_pkg::CMD_STAT;
				else if (roll < 92)
					w.cmd = lcdt_pkg::CMD_LCDC;
				else
					w.cmd = lcdt_pkg::CMD_LY;
				roll = $urandom_range(0, 2);
				w.pick = (roll == 0) ? LYC_NEXT : ((roll == 1) ? LYC_SAME : LYC_FREE);
			end
			pending_words.push_back(w);
		end
		total_words = pending_words.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every result word, then linger to catch strays
		while (words_seen < total_words)
			@(posedge clk);
		repeat (LINE_LATENCY) @(posedge clk);

		$display("Streamed %0d words, checked %0d results: %0d STAT and %0d VBLANK requests,",
			words_sent, words_seen, stat_irqs, vblank_irqs);
		$display("%0d frame-ready pulses and %0d rendered lines.", frames, rendered);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS lcd_mode_timing_stat_interrupts");
		else
			$display("FAIL lcd_mode_timing_stat_interrupts");
		$finish;
	end

endmodule
